### src/lss_pkg.sv
// Shared types and constants for the LIFO stack with search.
// No dependencies; every other file of the block imports this package.
package lss_pkg;

    // Stack geometry
    localparam int DEPTH  = 32;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;

    // Operation codes carried in the kind field
    localparam logic [2:0] KIND_PUSH   = 3'd0;
    localparam logic [2:0] KIND_POP    = 3'd1;
    localparam logic [2:0] KIND_PEEK   = 3'd2;
    localparam logic [2:0] KIND_SEARCH = 3'd3;
    localparam logic [2:0] KIND_DUMP   = 3'd4;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Memory access request from the sequencer to the entry RAM
    typedef struct packed {
        logic                     wr_en;
        logic [ADDR_W-1:0]        wr_addr;
        logic signed [WORD_W-1:0] wr_data;
        logic                     rd_en;
        logic [ADDR_W-1:0]        rd_addr;
    } lss_mem_req_t;

    // One result item
    typedef struct packed {
        logic [1:0]               status;
        logic signed [WORD_W-1:0] data;
        logic                     found;
        logic                     last;
    } lss_result_t;

endpackage

### src/lifo_stack_with_search_core.sv
// Top level of the LIFO stack with search.
// Depends on lss_pkg, lss_ram, lss_ctrl and lss_out_reg.
//
// Usage:
//   Input channel (in_valid/in_ready, kind, value) takes one operation per
//   transfer: push, pop, peek, search or dump. Codes 5 to 7 are dropped with
//   no result. Output channel (out_valid/out_ready, status, data, found,
//   last) carries result items; last marks the final result of an operation.
//   Search compares one entry per cycle; dump emits one entry per cycle
//   while the output register is free. Both rates come from the single
//   read port of the entry RAM, which the sequencer walks one address at a
//   time. A new operation is accepted once the previous one has placed its
//   final result in the output register.
//   Reset clears the fill count and the output register's valid flag; entries
//   need no clearing since only entries below the fill count are read.
//   When the receiver stalls, the result holds in the output register and a
//   dump pauses its walk until the slot frees.
module lifo_stack_with_search_core
    import lss_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [2:0]               kind,
    input  logic signed [WORD_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               status,
    output logic signed [WORD_W-1:0] data,
    output logic                     found,
    output logic                     last
);

    lss_mem_req_t             mem_req;
    logic signed [WORD_W-1:0] rd_data;
    logic                     out_free;
    logic                     out_load;
    lss_result_t              out_result;

    // Entry storage
    lss_ram u_ram (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // Operation sequencer
    lss_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .value      (value),
        .mem_req    (mem_req),
        .rd_data    (rd_data),
        .out_free   (out_free),
        .out_load   (out_load),
        .out_result (out_result)
    );

    // Result output register
    lss_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .result    (out_result),
        .free      (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .data      (data),
        .found     (found),
        .last      (last)
    );

endmodule

### src/lss_ram.sv
// Entry storage: one write port and one read port with registered read data.
// Depends on lss_pkg for geometry and the request struct.
module lss_ram
    import lss_pkg::*;
(
    input  logic                     clk,
    input  lss_mem_req_t             req,
    output logic signed [WORD_W-1:0] rd_data
);

    logic signed [WORD_W-1:0] mem [DEPTH];
    logic signed [WORD_W-1:0] rd_data_reg;

    // Write the pushed word
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Read one entry; hold the last word while no read is issued
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/lss_out_reg.sv
// Output register stage: holds one result item until the receiver takes it.
// Depends on lss_pkg for the result struct.
module lss_out_reg
    import lss_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  lss_result_t              result,
    output logic                     free,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               status,
    output logic signed [WORD_W-1:0] data,
    output logic                     found,
    output logic                     last
);

    logic        valid_reg;
    lss_result_t result_reg;

    // A new result may enter when the slot is empty or drains this cycle
    assign free = !valid_reg || out_ready;

    // Track occupancy of the slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Capture the payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign status    = result_reg.status;
    assign data      = result_reg.data;
    assign found     = result_reg.found;
    assign last      = result_reg.last;

endmodule

### src/lss_ctrl.sv
// Sequencer: decodes operations, keeps the fill count and walks the entry RAM.
// Depends on lss_pkg; drives lss_ram requests and loads lss_out_reg.
module lss_ctrl
    import lss_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [2:0]               kind,
    input  logic signed [WORD_W-1:0] value,
    output lss_mem_req_t             mem_req,
    input  logic signed [WORD_W-1:0] rd_data,
    input  logic                     out_free,
    output logic                     out_load,
    output lss_result_t              out_result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RESP,
        ST_RDATA,
        ST_SCAN,
        ST_DUMP
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         fill_reg, fill_next;
    logic [ADDR_W-1:0]        ptr_reg, ptr_next;
    logic signed [WORD_W-1:0] value_reg, value_next;
    logic                     hit_reg, hit_next;
    logic [1:0]               resp_status_reg, resp_status_next;
    logic                     resp_found_reg, resp_found_next;

    logic              is_empty;
    logic              is_full;
    logic [ADDR_W-1:0] top_addr;
    logic              hit_now;
    logic              accept;

    assign is_empty = (fill_reg == '0);
    assign is_full  = (fill_reg == CNT_W'(DEPTH));
    assign top_addr = ADDR_W'(fill_reg - CNT_W'(1));
    assign hit_now  = hit_reg || (rd_data == value_reg);
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Next-state logic
    always_comb
    begin
        state_next       = state_reg;
        fill_next        = fill_reg;
        ptr_next         = ptr_reg;
        value_next       = value_reg;
        hit_next         = hit_reg;
        resp_status_next = resp_status_reg;
        resp_found_next  = resp_found_reg;
        mem_req          = '0;
        out_load         = 1'b0;
        out_result       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    resp_found_next = 1'b0;
                    case (kind)
                        KIND_PUSH:
                        begin
                            state_next = ST_RESP;
                            if (is_full)
                            begin
                                resp_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                resp_status_next = STATUS_OK;
                                mem_req.wr_en    = 1'b1;
                                mem_req.wr_addr  = ADDR_W'(fill_reg);
                                mem_req.wr_data  = value;
                                fill_next        = fill_reg + CNT_W'(1);
                            end
                        end
                        KIND_POP, KIND_PEEK:
                        begin
                            if (is_empty)
                            begin
                                resp_status_next = STATUS_EMPTY;
                                state_next       = ST_RESP;
                            end
                            else
                            begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = top_addr;
                                state_next      = ST_RDATA;
                                if (kind == KIND_POP)
                                begin
                                    fill_next = fill_reg - CNT_W'(1);
                                end
                            end
                        end
                        KIND_SEARCH:
                        begin
                            if (is_empty)
                            begin
                                resp_status_next = STATUS_EMPTY;
                                state_next       = ST_RESP;
                            end
                            else
                            begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = '0;
                                ptr_next        = '0;
                                hit_next        = 1'b0;
                                value_next      = value;
                                state_next      = ST_SCAN;
                            end
                        end
                        KIND_DUMP:
                        begin
                            if (is_empty)
                            begin
                                resp_status_next = STATUS_EMPTY;
                                state_next       = ST_RESP;
                            end
                            else
                            begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = top_addr;
                                ptr_next        = top_addr;
                                state_next      = ST_DUMP;
                            end
                        end
                        default:
                        begin
                            // Unused codes: drop the item
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // Emit a single status-only result
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_load          = 1'b1;
                    out_result.status = resp_status_reg;
                    out_result.found  = resp_found_reg;
                    out_result.last   = 1'b1;
                    state_next        = ST_IDLE;
                end
            end

            // Emit the popped or peeked word
            ST_RDATA:
            begin
                if (out_free)
                begin
                    out_load          = 1'b1;
                    out_result.status = STATUS_OK;
                    out_result.data   = rd_data;
                    out_result.last   = 1'b1;
                    state_next        = ST_IDLE;
                end
            end

            // Compare one entry a cycle from the bottom up
            ST_SCAN:
            begin
                if (ptr_reg == top_addr)
                begin
                    resp_status_next = STATUS_OK;
                    resp_found_next  = hit_now;
                    state_next       = ST_RESP;
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = ptr_reg + ADDR_W'(1);
                    ptr_next        = ptr_reg + ADDR_W'(1);
                    hit_next        = hit_now;
                end
            end

            // Emit entries top to bottom; stall the walk while the output is full
            ST_DUMP:
            begin
                if (out_free)
                begin
                    out_load          = 1'b1;
                    out_result.status = STATUS_OK;
                    out_result.data   = rd_data;
                    out_result.last   = (ptr_reg == '0);
                    if (ptr_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = ptr_reg - ADDR_W'(1);
                        ptr_next        = ptr_reg - ADDR_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            fill_reg        <= '0;
            ptr_reg         <= '0;
            hit_reg         <= 1'b0;
            resp_status_reg <= STATUS_OK;
            resp_found_reg  <= 1'b0;
            value_reg       <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            fill_reg        <= fill_next;
            ptr_reg         <= ptr_next;
            hit_reg         <= hit_next;
            resp_status_reg <= resp_status_next;
            resp_found_reg  <= resp_found_next;
            value_reg       <= value_next;
        end
    end

endmodule

### src/lss_checker.sv
// Port-level checks for the LIFO stack with search, bound to the top level.
// Depends on lss_pkg for operation and status codes.
module lss_checker
    import lss_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic [2:0]               kind,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [1:0]               status,
    input logic signed [WORD_W-1:0] data,
    input logic                     found,
    input logic                     last
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(data)
            && $stable(found) && $stable(last))
        else $error("result changed while stalled");

    // Error statuses always end the operation
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> last)
        else $error("error result without last");

    // Error results carry no word and no hit
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> data == '0 && !found)
        else $error("error result carries payload");

    // A hit is only reported by a successful search, with no word
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> status == STATUS_OK && data == '0 && last)
        else $error("found set on a non-search result");

    // A valid operation blocks the input for at least the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == KIND_PUSH || kind == KIND_POP
            || kind == KIND_PEEK || kind == KIND_SEARCH || kind == KIND_DUMP)
        |=> !in_ready)
        else $error("input ready right after an operation transfer");

endmodule

bind lifo_stack_with_search_core lss_checker u_lss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .data      (data),
    .found     (found),
    .last      (last)
);

### verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for lifo_stack_with_search_core: a queued driver,
// a result monitor and an in-line stack predictor. Depends on lss_pkg.
module testbench;
    import lss_pkg::*;

    typedef struct {
        logic [2:0]               kind;
        logic signed [WORD_W-1:0] value;
    } stack_op_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    logic [2:0]               kind      = KIND_PUSH;
    logic signed [WORD_W-1:0] value     = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [1:0]               status;
    logic signed [WORD_W-1:0] data;
    logic                     found;
    logic                     last;

    // Stimulus and scoreboard storage
    stack_op_t                pending_ops[$];
    lss_result_t              expected_results[$];
    logic [WORD_W-1:0]        value_pool[$];
    int                       mismatch_count = 0;
    int                       n_accepted     = 0;

    // Predictor copy of the stack
    logic signed [WORD_W-1:0] stack_words[DEPTH];
    int                       stack_fill = 0;

    // Sender and receiver pacing state
    int                       burst_left      = 8;
    int                       gap_left        = 0;
    int                       rx_mode         = 0;
    int                       rx_phase_cycles = 0;
    int                       rx_tick         = 0;
    int                       hold_cycles     = 0;
    int                       holds_done      = 0;
    logic                     rx_hold         = 1'b0;

    // Generator bookkeeping
    int                       gen_fill   = 0;
    int                       random_ops = 0;

    lifo_stack_with_search_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .data      (data),
        .found     (found),
        .last      (last)
    );

    always #5 clk = ~clk;

    // Print one line per mismatch and count it
    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Apply one accepted operation to the stack copy and queue its results
    task automatic stack_predict(input logic [2:0] op_kind,
                                 input logic signed [WORD_W-1:0] op_value);
        lss_result_t res;
        logic        hit;
        int          i;
        res        = '0;
        res.status = STATUS_OK;
        res.last   = 1'b1;
        hit        = 1'b0;
        case (op_kind)
            KIND_PUSH:
            begin
                if (stack_fill >= DEPTH) begin
                    res.status = STATUS_FULL;
                end else begin
                    stack_words[stack_fill] = op_value;
                    stack_fill++;
                end
                expected_results.push_back(res);
            end
            KIND_POP, KIND_PEEK:
            begin
                if (stack_fill == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    res.data = stack_words[stack_fill - 1];
                    if (op_kind == KIND_POP)
                        stack_fill--;
                end
                expected_results.push_back(res);
            end
            KIND_SEARCH:
            begin
                if (stack_fill == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    for (i = 0; i < stack_fill; i++)
                        if (stack_words[i] == op_value)
                            hit = 1'b1;
                    res.found = hit;
                end
                expected_results.push_back(res);
            end
            KIND_DUMP:
            begin
                if (stack_fill == 0) begin
                    res.status = STATUS_EMPTY;
                    expected_results.push_back(res);
                end else begin
                    // Top of stack first, last flag on the bottom entry
                    for (i = stack_fill - 1; i >= 0; i--) begin
                        res.data = stack_words[i];
                        res.last = (i == 0);
                        expected_results.push_back(res);
                    end
                end
            end
            default:
            begin
                // Unused codes are dropped with no result
            end
        endcase
    endtask

    // Append one operation to the stimulus, tracking the expected depth
    task automatic queue_op(input logic [2:0] op_kind, input logic [WORD_W-1:0] op_value);
        stack_op_t op;
        op.kind  = op_kind;
        op.value = op_value;
        pending_ops.push_back(op);
        if (op_kind == KIND_PUSH && gen_fill < DEPTH) begin
            gen_fill++;
            value_pool.push_back(op_value);
            if (value_pool.size() > 24)
                void'(value_pool.pop_front());
        end else if (op_kind == KIND_POP && gen_fill > 0) begin
            gen_fill--;
        end
    endtask

    // Pick a word: mostly random, some extremes, some repeats for search hits
    function automatic logic [WORD_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel == 0)
            return 32'h7FFF_FFFF;
        else if (sel == 1)
            return 32'h8000_0000;
        else if (sel == 2)
            return 32'h0000_0000;
        else if (sel == 3)
            return 32'hFFFF_FFFF;
        else if (sel < 8 && value_pool.size() != 0)
            return value_pool[$urandom_range(0, value_pool.size() - 1)];
        return $urandom;
    endfunction

    // Build the stimulus, then wait for the scoreboard to drain
    initial
    begin : stimulus
        int episode;
        int count;
        int j;
        int sel;
        logic [2:0] op_kind;

        // Empty-stack cases
        queue_op(KIND_POP, 32'h0);
        queue_op(KIND_PEEK, 32'h0);
        queue_op(KIND_SEARCH, 32'h0);
        queue_op(KIND_DUMP, 32'h0);
        // Extremes of the word
        queue_op(KIND_PUSH, 32'h7FFF_FFFF);
        queue_op(KIND_PUSH, 32'h8000_0000);
        queue_op(KIND_PUSH, 32'h0000_0000);
        queue_op(KIND_PUSH, 32'hFFFF_FFFF);
        queue_op(KIND_PEEK, 32'h0);
        queue_op(KIND_SEARCH, 32'h8000_0000);
        queue_op(KIND_SEARCH, 32'h7FFF_FFFE);
        queue_op(KIND_DUMP, 32'h0);
        // Unused codes must leave no trace
        queue_op(3'd5, 32'hFFFF_FFFF);
        queue_op(3'd6, 32'h0000_0000);
        queue_op(3'd7, 32'hA5A5_5A5A);
        queue_op(KIND_POP, 32'h0);
        queue_op(KIND_SEARCH, 32'hFFFF_FFFF);
        queue_op(KIND_POP, 32'h0);
        queue_op(KIND_SEARCH, 32'h7FFF_FFFF);
        queue_op(KIND_POP, 32'h0);
        queue_op(KIND_POP, 32'h0);
        queue_op(KIND_POP, 32'h0);
        queue_op(KIND_DUMP, 32'h0);

        // Random episodes; the first one always fills the stack
        episode = 0;
        while (random_ops < 195) begin
            if (episode == 0 || $urandom_range(0, 9) < 2) begin
                // Fill to the top, overflow, then look at everything
                while (gen_fill < DEPTH) begin
                    queue_op(KIND_PUSH, pick_value());
                    random_ops++;
                end
                count = $urandom_range(1, 3);
                for (j = 0; j < count; j++) begin
                    queue_op(KIND_PUSH, pick_value());
                    random_ops++;
                end
                queue_op(KIND_SEARCH, pick_value());
                queue_op(KIND_DUMP, $urandom);
                random_ops += 2;
            end else if ($urandom_range(0, 7) < 2) begin
                // Drain to empty and go one past
                while (gen_fill > 0) begin
                    queue_op(KIND_POP, $urandom);
                    random_ops++;
                end
                queue_op($urandom_range(0, 1) ? KIND_POP : KIND_PEEK, $urandom);
                random_ops++;
            end else begin
                // Mixed traffic, biased toward push and search
                count = $urandom_range(10, 20);
                for (j = 0; j < count; j++) begin
                    sel = $urandom_range(0, 99);
                    if (sel < 35)
                        op_kind = KIND_PUSH;
                    else if (sel < 55)
                        op_kind = KIND_POP;
                    else if (sel < 65)
                        op_kind = KIND_PEEK;
                    else if (sel < 85)
                        op_kind = KIND_SEARCH;
                    else if (sel < 95)
                        op_kind = KIND_DUMP;
                    else
                        op_kind = 3'($urandom_range(5, 7));
                    queue_op(op_kind, pick_value());
                    if (op_kind <= KIND_DUMP)
                        random_ops++;
                end
            end
            episode++;
        end

        // Release reset
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the last transfer, the last result, then settle
        while (pending_ops.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Drive operations in bursts with random gaps; predict on each transfer
    always @(posedge clk)
    begin : drive_ops
        stack_op_t op;
        logic      next_valid;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            next_valid = in_valid;
            if (in_valid && in_ready) begin
                stack_predict(kind, value);
                n_accepted <= n_accepted + 1;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_ops.size() != 0) begin
                    op = pending_ops.pop_front();
                    kind  <= op.kind;
                    value <= op.value;
                    next_valid = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            in_valid <= next_valid;
        end
    end

    // Hold the receiver off for a long stretch, twice during the run
    always @(posedge clk)
    begin : long_holdoff
        if (!rst_n) begin
            rx_hold <= 1'b0;
        end else begin
            if (hold_cycles > 0) begin
                hold_cycles--;
            end else if ((holds_done == 0 && n_accepted >= 60) ||
                         (holds_done == 1 && n_accepted >= 170)) begin
                hold_cycles = 250;
                holds_done++;
            end
            rx_hold <= (hold_cycles > 0);
        end
    end

    // Pace the receiver: switch between stall patterns at random intervals
    always @(posedge clk)
    begin : pace_receiver
        logic go;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (rx_phase_cycles == 0) begin
                rx_mode         = $urandom_range(0, 3);
                rx_phase_cycles = $urandom_range(20, 80);
            end else begin
                rx_phase_cycles--;
            end
            rx_tick++;
            case (rx_mode)
                0:       go = 1'b1;
                1:       go = $urandom_range(0, 1);
                2:       go = (rx_tick % 4 == 0);
                default: go = ($urandom_range(0, 7) != 0);
            endcase
            out_ready <= go && !rx_hold;
        end
    end

    // Check each result transfer against the oldest expectation
    always @(posedge clk)
    begin : check_results
        lss_result_t exp_res;
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                flag_mismatch($sformatf("result with nothing expected: st=%0d d=%h f=%b l=%b",
                                        status, data, found, last));
            end else begin
                exp_res = expected_results.pop_front();
                if (status !== exp_res.status)
                    flag_mismatch($sformatf("status %0d, expected %0d",
                                            status, exp_res.status));
                if (data !== exp_res.data)
                    flag_mismatch($sformatf("data %h, expected %h", data, exp_res.data));
                if (found !== exp_res.found)
                    flag_mismatch($sformatf("found %b, expected %b", found, exp_res.found));
                if (last !== exp_res.last)
                    flag_mismatch($sformatf("last %b, expected %b", last, exp_res.last));
            end
        end
    end

    // Watchdog
    initial
    begin : watchdog
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### lifo_stack_with_search_core.f
src/lss_pkg.sv
src/lss_ram.sv
src/lss_out_reg.sv
src/lss_ctrl.sv
src/lifo_stack_with_search_core.sv
src/lss_checker.sv
verif/testbench.sv
